@@ rtl/core/bba_pkg.sv @@
package bba_pkg;

    // Widths fixed by the item format.
    localparam int REQ_W = 21;
    localparam int TAG_W = 2;
    localparam int STAT_W = 2;

    // Node states.
    localparam logic [TAG_W-1:0] TAG_FREE  = 2'd0;
    localparam logic [TAG_W-1:0] TAG_SPLIT = 2'd1;
    localparam logic [TAG_W-1:0] TAG_ALLOC = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMEM    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADREQ   = 2'd3;

    // Operation selector.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Write strobes of the tree memories.
    typedef struct packed {
        logic tag_we;
        logic req_we;
    } bba_mem_ctl_t;

endpackage

@@ rtl/core/bba_tree_mem.sv @@
module bba_tree_mem
    import bba_pkg::*;
#(
    parameter int ADDR_W = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  bba_mem_ctl_t      ctl,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [TAG_W-1:0]  wr_tag,
    input  logic [REQ_W-1:0]  wr_req,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [TAG_W-1:0]  rd_tag,
    output logic [REQ_W-1:0]  rd_req,
    output logic              busy
);

    localparam int DEPTH = (1 << ADDR_W) - 1;

    logic [TAG_W-1:0]  tag_mem [DEPTH];
    logic [REQ_W-1:0]  req_mem [DEPTH];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              tag_we;
    logic              req_we;
    logic [ADDR_W-1:0] waddr;
    logic [TAG_W-1:0]  wtag;
    logic [REQ_W-1:0]  wreq;

    // The clearing pass after reset owns the write port.
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            tag_we = 1'b1;
            req_we = 1'b1;
            waddr  = clr_cnt_reg;
            wtag   = TAG_FREE;
            wreq   = '0;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
        end
        else
        begin
            tag_we = ctl.tag_we;
            req_we = ctl.req_we;
            waddr  = wr_addr;
            wtag   = wr_tag;
            wreq   = wr_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    // Tag and request memories, registered read.
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[waddr] <= wtag;
        end
        if (req_we)
        begin
            req_mem[waddr] <= wreq;
        end
        rd_tag <= tag_mem[rd_addr];
        rd_req <= req_mem[rd_addr];
    end

    assign busy = busy_reg;

endmodule

@@ rtl/core/buddy_block_allocator_core.sv @@
// Channel   | Direction | Beat contents
// s_axis    | in        | tdata: request_size; tuser: func
// m_axis    | out       | tdata: status, node_index, block_size
// cfg       | in        | cfg_wr_data: total_size, written when cfg_wr_en is high
//
// One item at a time. Allocate first picks the level, then checks the nodes of that
// level in turn, each with its ancestors, then marks the ancestors split. Free scans
// the nodes one per cycle in index order, then merges upward level by level. The tree
// memory has a single read port. After reset a clearing pass writes every node free
// before an item is taken. A held result does not stop the next beat from being
// accepted.
module buddy_block_allocator_core
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [20:0] request_size
    input  logic [23:0]            s_axis_tdata,
    // [0] func
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, then node_index, then block_size
    output logic [((STAT_W + TREE_LEVELS + REQ_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                   cfg_wr_en,
    input  logic [REQ_W-1:0]       cfg_wr_data
);

    localparam int NW    = TREE_LEVELS;
    localparam int DEPTH = (1 << TREE_LEVELS) - 1;
    localparam int LVL_W = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
    localparam int PAY_W = STAT_W + NW + REQ_W;
    localparam int OUT_W = ((PAY_W + 7) / 8) * 8;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LEVEL = 4'd1;
    localparam logic [3:0] S_ACHK  = 4'd2;
    localparam logic [3:0] S_AANC  = 4'd3;
    localparam logic [3:0] S_AMARK = 4'd4;
    localparam logic [3:0] S_AUP   = 4'd5;
    localparam logic [3:0] S_FSCAN = 4'd6;
    localparam logic [3:0] S_FCLR  = 4'd7;
    localparam logic [3:0] S_FMCHK = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    function automatic logic [NW-1:0] parent_of(input logic [NW-1:0] n);
        logic [NW-1:0] m;
        m = n - NW'(1);
        return m >> 1;
    endfunction

    function automatic logic [NW-1:0] buddy_of(input logic [NW-1:0] n);
        return n[0] ? (n + NW'(1)) : (n - NW'(1));
    endfunction

    function automatic logic [LVL_W-1:0] depth_of(input logic [NW-1:0] n);
        logic [NW-1:0]    m;
        logic [LVL_W-1:0] d;
        m = n + NW'(1);
        d = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (m[i])
            begin
                d = LVL_W'(i);
            end
        end
        return d;
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [NW-1:0]     addr_reg, addr_next;
    logic [NW-1:0]     cand_reg, cand_next;
    logic [NW-1:0]     walk_reg, walk_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [REQ_W-1:0]  size_reg, size_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [REQ_W-1:0]  total_reg;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [NW-1:0]     res_node_reg, res_node_next;
    logic [REQ_W-1:0]  res_size_reg, res_size_next;
    logic              out_valid_reg;
    logic [PAY_W-1:0]  out_data_reg;
    logic              out_load;

    bba_mem_ctl_t      mem_ctl;
    logic [NW-1:0]     wr_addr;
    logic [TAG_W-1:0]  wr_tag;
    logic [REQ_W-1:0]  wr_req;
    logic [TAG_W-1:0]  rd_tag;
    logic [REQ_W-1:0]  rd_req;
    logic              mem_busy;

    logic              cand_last;
    logic [NW-1:0]     level_first;
    logic [LVL_W-1:0]  hit_depth;
    logic [NW-1:0]     par_walk;
    logic [REQ_W-1:0]  req_in;

    bba_tree_mem #(
        .ADDR_W (NW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_tag  (wr_tag),
        .wr_req  (wr_req),
        .rd_addr (addr_next),
        .rd_tag  (rd_tag),
        .rd_req  (rd_req),
        .busy    (mem_busy)
    );

    // Level bookkeeping helpers.
    assign cand_last   = ({1'b0, cand_reg} + (NW+1)'(2)) == ((NW+1)'(2) << level_reg);
    assign level_first = (NW'(1) << level_reg) - NW'(1);
    assign hit_depth   = depth_of(cand_reg);
    assign par_walk    = parent_of(walk_reg);
    assign req_in      = s_axis_tdata[REQ_W-1:0];

    assign s_axis_tready = (state_reg == S_IDLE) && !mem_busy;

    // Operation sequencer.
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        cand_next       = cand_reg;
        walk_next       = walk_reg;
        req_next        = req_reg;
        size_next       = size_reg;
        level_next      = level_reg;
        res_status_next = res_status_reg;
        res_node_next   = res_node_reg;
        res_size_next   = res_size_reg;
        mem_ctl         = '0;
        wr_addr         = cand_reg;
        wr_tag          = TAG_FREE;
        wr_req          = '0;
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    req_next        = req_in;
                    res_status_next = STAT_NOMEM;
                    res_node_next   = '0;
                    res_size_next   = '0;
                    if (req_in == '0)
                    begin
                        res_status_next = STAT_BADREQ;
                        state_next      = S_FIN;
                    end
                    else if (s_axis_tuser == OP_FREE)
                    begin
                        addr_next  = '0;
                        state_next = S_FSCAN;
                    end
                    else if (req_in > total_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        size_next  = total_reg;
                        level_next = '0;
                        state_next = S_LEVEL;
                    end
                end
            end
            S_LEVEL:
            begin
                if ((level_reg < LVL_W'(TREE_LEVELS - 1))
                    && !(req_reg <= size_reg && req_reg > (size_reg >> 1)))
                begin
                    size_next  = size_reg >> 1;
                    level_next = level_reg + LVL_W'(1);
                end
                else
                begin
                    cand_next  = level_first;
                    addr_next  = level_first;
                    state_next = S_ACHK;
                end
            end
            S_ACHK, S_AANC:
            begin
                if ((state_reg == S_ACHK) ? (rd_tag != TAG_FREE) : (rd_tag == TAG_ALLOC))
                begin
                    // Candidate unusable: move right along the level.
                    if (cand_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cand_next  = cand_reg + NW'(1);
                        addr_next  = cand_reg + NW'(1);
                        state_next = S_ACHK;
                    end
                end
                else if (addr_reg == '0)
                begin
                    state_next = S_AMARK;
                end
                else
                begin
                    addr_next  = parent_of(addr_reg);
                    state_next = S_AANC;
                end
            end
            S_AMARK:
            begin
                mem_ctl.tag_we = 1'b1;
                mem_ctl.req_we = 1'b1;
                wr_tag         = TAG_ALLOC;
                wr_req         = req_reg;
                walk_next      = cand_reg;
                state_next     = S_AUP;
            end
            S_AUP:
            begin
                if (walk_reg == '0)
                begin
                    res_status_next = STAT_OK;
                    res_node_next   = cand_reg;
                    res_size_next   = total_reg >> level_reg;
                    state_next      = S_FIN;
                end
                else
                begin
                    mem_ctl.tag_we = 1'b1;
                    wr_addr        = par_walk;
                    wr_tag         = TAG_SPLIT;
                    walk_next      = par_walk;
                end
            end
            S_FSCAN:
            begin
                if (rd_tag == TAG_ALLOC && rd_req == req_reg)
                begin
                    cand_next  = addr_reg;
                    state_next = S_FCLR;
                end
                else if (addr_reg == NW'(DEPTH - 1))
                begin
                    res_status_next = STAT_NOTFOUND;
                    state_next      = S_FIN;
                end
                else
                begin
                    addr_next = addr_reg + NW'(1);
                end
            end
            S_FCLR:
            begin
                mem_ctl.tag_we  = 1'b1;
                mem_ctl.req_we  = 1'b1;
                walk_next       = cand_reg;
                res_status_next = STAT_OK;
                res_node_next   = cand_reg;
                res_size_next   = total_reg >> hit_depth;
                if (cand_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    addr_next  = buddy_of(cand_reg);
                    state_next = S_FMCHK;
                end
            end
            S_FMCHK:
            begin
                // Merge upward while the buddy is free as well.
                if (rd_tag == TAG_FREE)
                begin
                    mem_ctl.tag_we = 1'b1;
                    mem_ctl.req_we = 1'b1;
                    wr_addr        = par_walk;
                    walk_next      = par_walk;
                    if (par_walk == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        addr_next = buddy_of(par_walk);
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= REQ_W'(1024);
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                total_reg <= cfg_wr_data;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        cand_reg       <= cand_next;
        walk_reg       <= walk_next;
        req_reg        <= req_next;
        size_reg       <= size_next;
        level_reg      <= level_next;
        res_status_reg <= res_status_next;
        res_node_reg   <= res_node_next;
        res_size_reg   <= res_size_next;
        if (out_load)
        begin
            out_data_reg <= {res_size_next, res_node_next, res_status_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

endmodule

@@ tb/sv/buddy_block_allocator_core_checker.sv @@
module buddy_block_allocator_core_checker
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [20:0] cfg_wr_data,
    output int          outstanding,
    output int          error_count
);

    localparam int LEVELS = 11;
    localparam int NODES = (1 << LEVELS) - 1;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [10:0]       node;
        logic [20:0]       size;
    } alloc_reply_t;

    // Shadow copy of the tree and the root size.
    logic [TAG_W-1:0] shadow_tag [NODES] = '{default: TAG_FREE};
    logic [20:0]      shadow_req [NODES] = '{default: 21'd0};
    logic [20:0]      root_size = 21'd1024;
    alloc_reply_t     expected_replies [$];

    function automatic int node_depth(int n);
        int d;
        d = 0;
        while (d + 1 < LEVELS && n >= (1 << (d + 1)) - 1)
            d++;
        return d;
    endfunction

    function automatic bit under_allocated(int n);
        int p;
        p = n;
        while (p != 0)
        begin
            p = (p - 1) >> 1;
            if (shadow_tag[p] == TAG_ALLOC)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Allocation: pick the level, then the first usable node on it.
    function automatic alloc_reply_t allocate_block(logic [20:0] req);
        alloc_reply_t r;
        logic [20:0] sz;
        int lvl;
        int p;
        r = '{STAT_NOMEM, 11'd0, 21'd0};
        if (req > root_size)
            return r;
        sz = root_size;
        lvl = 0;
        while (lvl + 1 < LEVELS && !(req <= sz && req > (sz >> 1)))
        begin
            sz = sz >> 1;
            lvl++;
        end
        for (int n = (1 << lvl) - 1; n <= (1 << (lvl + 1)) - 2; n++)
        begin
            if (shadow_tag[n] == TAG_FREE && !under_allocated(n))
            begin
                shadow_tag[n] = TAG_ALLOC;
                shadow_req[n] = req;
                p = n;
                while (p != 0)
                begin
                    p = (p - 1) >> 1;
                    shadow_tag[p] = TAG_SPLIT;
                end
                r = '{STAT_OK, 11'(n), root_size >> lvl};
                return r;
            end
        end
        return r;
    endfunction

    // Release: lowest allocated node holding the size, then merge upward.
    function automatic alloc_reply_t release_block(logic [20:0] req);
        alloc_reply_t r;
        int hit;
        int n;
        int bud;
        hit = -1;
        for (int i = 0; i < NODES; i++)
        begin
            if (hit < 0 && shadow_tag[i] == TAG_ALLOC && shadow_req[i] == req)
                hit = i;
        end
        if (hit < 0)
        begin
            r = '{STAT_NOTFOUND, 11'd0, 21'd0};
            return r;
        end
        shadow_tag[hit] = TAG_FREE;
        shadow_req[hit] = '0;
        n = hit;
        while (n != 0)
        begin
            bud = (n & 1) ? n + 1 : n - 1;
            if (shadow_tag[n] != TAG_FREE || shadow_tag[bud] != TAG_FREE)
                break;
            n = (n - 1) >> 1;
            shadow_tag[n] = TAG_FREE;
            shadow_req[n] = '0;
        end
        r = '{STAT_OK, 11'(hit), root_size >> node_depth(hit)};
        return r;
    endfunction

    // Watch all channels at the rising edge.
    always @(posedge clk)
    begin
        alloc_reply_t want;
        alloc_reply_t got;
        logic [20:0] req;
        if (cfg_wr_en)
            root_size = cfg_wr_data;
        if (s_axis_tvalid && s_axis_tready)
        begin
            req = s_axis_tdata[20:0];
            if (req == '0)
                want = '{STAT_BADREQ, 11'd0, 21'd0};
            else if (s_axis_tuser == OP_ALLOC)
                want = allocate_block(req);
            else
                want = release_block(req);
            expected_replies.push_back(want);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[1:0], m_axis_tdata[12:2], m_axis_tdata[33:13]};
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected beat, actual status %0d node %0d size %0d",
                         $time, got.status, got.node, got.size);
                error_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.node !== want.node)
                begin
                    $display("%0t: node_index expected %0d actual %0d",
                             $time, want.node, got.node);
                    error_count++;
                end
                if (got.size !== want.size)
                begin
                    $display("%0t: block_size expected %0d actual %0d",
                             $time, want.size, got.size);
                    error_count++;
                end
            end
        end
        outstanding = expected_replies.size();
    end

endmodule

@@ tb/sv/buddy_block_allocator_core_test.sv @@
module buddy_block_allocator_core_test;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [20:0] cfg_wr_data = '0;

    int          outstanding;
    int          error_count;
    int          cycle_count = 0;
    bit          s_fired = 1'b0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    logic [20:0] root_now = 21'd1024;
    logic [20:0] live_sizes [$];

    always #6 clk = ~clk;

    buddy_block_allocator_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    buddy_block_allocator_core_checker checker_i (
        .clk(clk),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .outstanding(outstanding),
        .error_count(error_count)
    );

    // Remember whether the request beat went through at the last edge.
    always @(posedge clk)
        s_fired <= s_axis_tvalid && s_axis_tready;

    // Result side: random back-pressure, with a single long hold-off.
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
            hold_left = 3000;
        if (hold_left > 0)
        begin
            hold_left--;
            if (hold_left == 0)
                hold_req = 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= quiet || ($urandom_range(99) >= 36);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("buddy_block_allocator_core: mismatch");
            $finish;
        end
    end

    // Offer one request beat and wait until it is taken.
    task automatic send_request(logic op, logic [20:0] req);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, req};
        @(negedge clk);
        while (!s_fired)
            @(negedge clk);
        s_axis_tvalid <= 1'b0;
        if (op == OP_ALLOC && req != '0)
            live_sizes.push_back(req);
    endtask

    // Let every result drain, then write the root size.
    task automatic set_root(logic [20:0] value);
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        root_now = value;
    endtask

    // One random request, mostly legal allocations and frees of live sizes.
    task automatic random_request();
        int pick;
        int idx;
        logic [20:0] req;
        pick = $urandom_range(99);
        if (pick < 48)
        begin
            if ($urandom_range(1))
                req = 21'($urandom_range(root_now > 64 ? root_now / 64 : 1, 1));
            else
                req = 21'($urandom_range(root_now, 1));
            send_request(OP_ALLOC, req);
        end
        else if (pick < 88 && live_sizes.size() > 0)
        begin
            idx = $urandom_range(live_sizes.size() - 1);
            req = live_sizes[idx];
            live_sizes.delete(idx);
            send_request(OP_FREE, req);
        end
        else if (pick < 94)
            send_request(1'($urandom_range(1)), 21'd0);
        else
            send_request(1'($urandom_range(1)), 21'($urandom));
    endtask

    initial
    begin
        logic [20:0] roots [5];
        roots = '{21'd1048576, 21'd1, 21'd1000, 21'd65536, 21'd1024};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset size.
        send_request(OP_ALLOC, 21'd0);
        send_request(OP_FREE, 21'd0);
        send_request(OP_FREE, 21'd5);
        send_request(OP_ALLOC, 21'd1025);
        send_request(OP_ALLOC, 21'h1FFFFF);
        send_request(OP_ALLOC, 21'd1);
        send_request(OP_ALLOC, 21'd1);
        send_request(OP_ALLOC, 21'd1024);
        send_request(OP_ALLOC, 21'd512);
        send_request(OP_ALLOC, 21'd300);
        send_request(OP_ALLOC, 21'd257);
        send_request(OP_ALLOC, 21'd256);
        send_request(OP_FREE, 21'd1);
        send_request(OP_FREE, 21'd1);
        send_request(OP_FREE, 21'd1);
        send_request(OP_FREE, 21'd300);
        send_request(OP_FREE, 21'd512);
        send_request(OP_ALLOC, 21'd1024);
        send_request(OP_FREE, 21'd1024);
        send_request(OP_FREE, 21'd257);
        send_request(OP_FREE, 21'd256);
        send_request(OP_ALLOC, 21'd1048576);
        live_sizes.delete();

        // Random phases at several root sizes; the tree carries over.
        foreach (roots[p])
        begin
            set_root(roots[p]);
            quiet = (p == 3);
            for (int i = 0; i < 54; i++)
            begin
                if (p == 1 && i == 10)
                    hold_req = 1'b1;
                random_request();
            end
            quiet = 1'b0;
        end

        while (outstanding != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (error_count == 0)
            $display("buddy_block_allocator_core: match");
        else
            $display("buddy_block_allocator_core: mismatch");
        $finish;
    end

endmodule
